@@ rtl/t64lin_pkg.sv @@
// types, constants and register indexes for the 64x32-tiled to linear address generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package t64lin_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int CFG_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 14;
    localparam int COORD_W    = 12;
    localparam int ADDR_W     = 25;

    localparam int TX_W       = 6;
    localparam int TY_W       = 7;
    localparam int INNER_W    = 11;
    localparam int COLS_W     = 7;
    localparam int ROWS_W     = 8;
    localparam int IDX_W      = 14;
    localparam int LTILES_W   = 15;
    localparam int CTILES_W   = 14;

    localparam logic [DIM_W-1:0]   MAX_WIDTH_C  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]   MAX_HEIGHT_C = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0]   RST_WIDTH    = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_HEIGHT   = DIM_W'(480);
    localparam logic [PITCH_W-1:0] RST_PITCH    = PITCH_W'(640);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_LINE_PITCH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               plane_sel;
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] source_offset;
        logic [ADDR_W-1:0] dest_offset;
        logic              copied;
        logic [ADDR_W-1:0] tiled_size;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [PITCH_W-1:0] line_pitch;
    } cfg_t;

    // values handed from the first arithmetic stage to the second
    typedef struct packed {
        logic                plane_sel;
        logic                copied;
        logic [TX_W-1:0]     tx;
        logic [INNER_W-1:0]  inner;
        logic [IDX_W-1:0]    band_base;
        logic [TY_W-1:0]     zz_add;
        logic [LTILES_W-1:0] luma_tiles;
        logic [CTILES_W-1:0] chroma_tiles;
        logic [ADDR_W-1:0]   row_prod;
        logic [COORD_W-1:0]  pixel_col;
    } mid_t;

endpackage

`default_nettype wire

@@ rtl/t64lin_front.sv @@
// first arithmetic stage: frame geometry, tile coordinates, products and copy flag
// depends on t64lin_pkg
`timescale 1ns / 1ps
`default_nettype none

module t64lin_front
    import t64lin_pkg::*;
(
    input  wire cfg_t     cfg,
    input  wire in_item_t item,
    output mid_t          mid
);

    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [DIM_W:0]      w_up;
    logic [DIM_W:0]      h_up;
    logic [DIM_W-1:0]    hh_up;
    logic [COLS_W-1:0]   cols;
    logic [COLS_W-1:0]   cols_even;
    logic [ROWS_W-1:0]   rows_luma;
    logic [ROWS_W-1:0]   rows_chroma;
    logic [ROWS_W-1:0]   rows_sel;
    logic [TX_W-1:0]     tx;
    logic [TY_W-1:0]     ty;
    logic [ROWS_W-1:0]   ty_next;
    logic [TY_W-1:0]     odd_add;
    logic [TY_W-1:0]     even_add;
    logic [DIM_W-1:0]    row_limit;
    logic [2*PITCH_W-1:0] row_prod_full;

    always_comb begin
        w = (cfg.frame_width  > MAX_WIDTH_C)  ? MAX_WIDTH_C  : cfg.frame_width;
        h = (cfg.frame_height > MAX_HEIGHT_C) ? MAX_HEIGHT_C : cfg.frame_height;

        w_up        = {1'b0, w} + (DIM_W+1)'(63);
        h_up        = {1'b0, h} + (DIM_W+1)'(31);
        hh_up       = {1'b0, h[DIM_W-1:1]} + DIM_W'(31);
        cols        = w_up[DIM_W-1:6];
        cols_even   = (cols + COLS_W'(1)) & ~COLS_W'(1);
        rows_luma   = h_up[DIM_W-1:5];
        rows_chroma = hh_up[DIM_W-1:5];
        rows_sel    = item.plane_sel ? rows_chroma : rows_luma;

        tx      = item.pixel_col[COORD_W-1:6];
        ty      = item.pixel_row[COORD_W-1:5];
        ty_next = {1'b0, ty} + ROWS_W'(1);

        // zig-zag step within a pair of tile rows
        odd_add  = {1'b0, tx[TX_W-1:2], 2'b00} + TY_W'(2);
        even_add = ({1'b0, tx} + TY_W'(2)) & ~TY_W'(3);

        if (ty[0]) begin
            mid.zz_add = odd_add;
        end else if (!rows_sel[0] || ty_next != rows_sel) begin
            mid.zz_add = even_add;
        end else begin
            mid.zz_add = '0;
        end

        row_limit  = item.plane_sel ? {1'b0, h[DIM_W-1:1]} : (h & ~DIM_W'(1));
        mid.copied = ({1'b0, item.pixel_col} < w) && ({1'b0, item.pixel_row} < row_limit);

        mid.plane_sel    = item.plane_sel;
        mid.tx           = tx;
        mid.inner        = {item.pixel_row[4:0], item.pixel_col[5:0]};
        mid.band_base    = IDX_W'({ty[TY_W-1:1], 1'b0}) * IDX_W'(cols_even);
        mid.luma_tiles   = LTILES_W'(cols_even) * LTILES_W'(rows_luma);
        mid.chroma_tiles = CTILES_W'(cols_even) * CTILES_W'(rows_chroma);
        row_prod_full    = {{(PITCH_W-COORD_W){1'b0}}, item.pixel_row} * cfg.line_pitch;
        mid.row_prod     = row_prod_full[ADDR_W-1:0];
        mid.pixel_col    = item.pixel_col;
    end

endmodule

`default_nettype wire

@@ rtl/t64lin_back.sv @@
// second arithmetic stage: plane sizes, tile index and final offsets
// depends on t64lin_pkg
`timescale 1ns / 1ps
`default_nettype none

module t64lin_back
    import t64lin_pkg::*;
(
    input  wire mid_t  mid,
    output out_item_t  res
);

    logic [LTILES_W-1:0] luma_round;
    logic [CTILES_W-1:0] chroma_round;
    logic [ADDR_W-1:0]   luma_bytes;
    logic [ADDR_W-1:0]   chroma_size;
    logic [IDX_W-1:0]    idx;
    logic [ADDR_W-1:0]   tile_off;

    always_comb begin
        // round tile counts up to a group of four tiles
        luma_round   = (mid.luma_tiles + LTILES_W'(3)) & ~LTILES_W'(3);
        chroma_round = (mid.chroma_tiles + CTILES_W'(3)) & ~CTILES_W'(3);
        luma_bytes   = {luma_round[IDX_W-1:0], {INNER_W{1'b0}}};
        chroma_size  = {chroma_round[IDX_W-1:0], {INNER_W{1'b0}}};

        idx      = mid.band_base + IDX_W'(mid.tx) + IDX_W'(mid.zz_add);
        tile_off = {idx, mid.inner};

        res.source_offset = mid.plane_sel ? (luma_bytes + tile_off) : tile_off;
        res.dest_offset   = mid.row_prod + ADDR_W'(mid.pixel_col);
        res.copied        = mid.copied;
        res.tiled_size    = luma_bytes + chroma_size;
    end

endmodule

`default_nettype wire

@@ rtl/tiled_64x32_to_linear_address.sv @@
// top level of the 64x32-tiled to linear NV12 address generator
// depends on t64lin_pkg, t64lin_front, t64lin_back
//
// One result item leaves for every input item, in order. The block is a three-register
// pipeline (input register, middle register, result register) with two short arithmetic
// stages between them, so it takes one item per cycle while the result side does not stall;
// each item passes through the input, middle and result registers in turn before its result
// is offered. A stall on the result side holds the result register, and an earlier stage
// holds only while the next stage is full and held; the input side keeps taking items while
// any stage is free. The geometry is worked out from the configuration registers as each
// item leaves the input register; new width, height and pitch act on items leaving it later.
`timescale 1ns / 1ps
`default_nettype none

module tiled_64x32_to_linear_address
    import t64lin_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,

    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_wdata,

    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire in_item_t        s_item,

    output logic                 m_valid,
    input  wire                  m_ready,
    output out_item_t            m_item
);

    cfg_t      cfg_reg;
    in_item_t  in_reg;
    mid_t      mid_reg;
    out_item_t out_reg;
    logic      in_valid_reg;
    logic      mid_valid_reg;
    logic      out_valid_reg;

    mid_t      mid_next;
    out_item_t out_next;
    logic      ld_in;
    logic      ld_mid;
    logic      ld_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= RST_WIDTH;
            cfg_reg.frame_height <= RST_HEIGHT;
            cfg_reg.line_pitch   <= RST_PITCH;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[DIM_W-1:0];
                CFG_LINE_PITCH:   cfg_reg.line_pitch   <= cfg_wdata[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance
    always_comb begin
        ld_out  = mid_valid_reg && (!out_valid_reg || m_ready);
        ld_mid  = in_valid_reg && (!mid_valid_reg || ld_out);
        s_ready = !in_valid_reg || ld_mid;
        ld_in   = s_valid && s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= ld_in  || (in_valid_reg  && !ld_mid);
            mid_valid_reg <= ld_mid || (mid_valid_reg && !ld_out);
            out_valid_reg <= ld_out || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_in) begin
            in_reg <= s_item;
        end
        if (ld_mid) begin
            mid_reg <= mid_next;
        end
        if (ld_out) begin
            out_reg <= out_next;
        end
    end

    t64lin_front u_front (
        .cfg  (cfg_reg),
        .item (in_reg),
        .mid  (mid_next)
    );

    t64lin_back u_back (
        .mid (mid_reg),
        .res (out_next)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

@@ rtl/t64lin_checker.sv @@
// port-level checks for the 64x32-tiled to linear address generator, bound to the top level
// depends on t64lin_pkg and tiled_64x32_to_linear_address
`timescale 1ns / 1ps
`default_nettype none

module t64lin_checker
    import t64lin_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire in_item_t       s_item,
    input wire                 m_valid,
    input wire                 m_ready,
    input wire out_item_t      m_item
);

    // a stalled input item holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while stalled");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side only stalls when the result side is full and stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with room in the pipeline");

    // both plane sizes are whole groups of four tiles
    a_size_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.tiled_size[12:0] == 13'd0)
        else $error("tiled size not group aligned");

endmodule

bind tiled_64x32_to_linear_address t64lin_checker u_t64lin_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_item    (s_item),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item)
);

`default_nettype wire
